[rtl/core/lsfr_pkg.sv]
// ----------------------------------------------------------------------------
// lsfr_pkg
// Shared types and constants for the limited-slope face reconstruction pipe.
// ----------------------------------------------------------------------------
package lsfr_pkg;

  localparam int QW       = 32;           // quotient / slope width, unsigned Q16.16
  localparam int MW       = 33;           // difference magnitude width
  localparam int FRAC     = 16;
  localparam int DIV_STGS = QW;           // one quotient bit per stage
  localparam int DIV_LAT  = DIV_STGS + 1; // entry stage plus bit stages

  localparam logic [QW-1:0] SMAX = '1;

  // per-item data that rides along with the dividers
  typedef struct packed {
    logic               active;    // both neighbours, same-sign nonzero differences
    logic               neg;       // slope sign
    logic               sum_zero;  // both extended volumes zero
    logic signed [31:0] phi;
    logic [30:0]        near_m;
    logic [30:0]        near_p;
    logic [30:0]        swept_m;
    logic [30:0]        swept_p;
  } side_t;

  typedef struct packed {
    logic [QW-1:0] sn;
    logic [QW-1:0] sp;
    logic [QW-1:0] rn;
    logic [QW-1:0] rp;
    logic [QW-1:0] wn;
  } quo_t;

endpackage

[rtl/core/limited_slope_face_reconstruction.sv]
// Throughput: one item per cycle while the output is not stalled; the dividers' 32 bit stages set the depth.
// The whole pipe advances together and holds when the output is stalled.
// Reset (rst_n low, synchronous) clears the valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// limited_slope_face_reconstruction
// Monotone limited-slope reconstruction of both face values of one cell.
// ----------------------------------------------------------------------------
module limited_slope_face_reconstruction import lsfr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // phi_prev[31:0], phi_cell[63:32], phi_next[95:64], near_minus[126:96],
  // near_plus[157:127], far_minus[188:158], far_plus[219:189],
  // swept_minus[250:220], swept_plus[281:251], zero pad[287:282]
  input  logic [287:0] in_tdata,
  // has_prev[0], has_next[1]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // face_minus[31:0], face_plus[63:32]
  output logic [63:0]  out_tdata,
  // valid_minus[0], valid_plus[1]
  output logic [1:0]   out_tuser
);

  localparam int LAT = 1 + DIV_LAT + 4;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---- unpack
  logic signed [31:0] phi_prev, phi_cell, phi_next;
  logic [30:0] near_minus, near_plus, far_minus, far_plus, swept_minus, swept_plus;
  assign phi_prev    = in_tdata[31:0];
  assign phi_cell    = in_tdata[63:32];
  assign phi_next    = in_tdata[95:64];
  assign near_minus  = in_tdata[126:96];
  assign near_plus   = in_tdata[157:127];
  assign far_minus   = in_tdata[188:158];
  assign far_plus    = in_tdata[219:189];
  assign swept_minus = in_tdata[250:220];
  assign swept_plus  = in_tdata[281:251];

  // ---- entry stage: differences and extended volumes
  logic signed [32:0] dn, dp;
  logic               both_pos, both_neg;
  logic [MW-1:0]      an_r, ap_r;
  logic [31:0]        dnv_r, dpv_r;
  logic [32:0]        sum_nxt, sum_r;
  side_t              side_nxt, side0_r;

  assign dn = $signed({phi_next[31], phi_next}) - $signed({phi_cell[31], phi_cell});
  assign dp = $signed({phi_cell[31], phi_cell}) - $signed({phi_prev[31], phi_prev});
  assign both_pos = (dn > 0) && (dp > 0);
  assign both_neg = dn[32] && dp[32];
  assign sum_nxt  = {2'b0, near_plus} + {2'b0, far_plus} +
                    {2'b0, near_minus} + {2'b0, far_minus};

  always_comb begin
    side_nxt.active   = in_tuser[0] && in_tuser[1] && (both_pos || both_neg);
    side_nxt.neg      = both_neg;
    side_nxt.sum_zero = (sum_nxt == '0);
    side_nxt.phi      = phi_cell;
    side_nxt.near_m   = near_minus;
    side_nxt.near_p   = near_plus;
    side_nxt.swept_m  = swept_minus;
    side_nxt.swept_p  = swept_plus;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      an_r    <= dn[32] ? MW'(-dn) : MW'(dn);
      ap_r    <= dp[32] ? MW'(-dp) : MW'(dp);
      dnv_r   <= {1'b0, near_plus} + {1'b0, far_plus};
      dpv_r   <= {1'b0, near_minus} + {1'b0, far_minus};
      sum_r   <= sum_nxt;
      side0_r <= side_nxt;
    end
  end

  // ---- dividers
  quo_t quo;

  lsfr_div u_div_sn (.clk, .en, .num_i(an_r), .den_i({2'b0, side0_r.near_p}),
                     .quo_o(quo.sn));
  lsfr_div u_div_sp (.clk, .en, .num_i(ap_r), .den_i({2'b0, side0_r.near_m}),
                     .quo_o(quo.sp));
  lsfr_div u_div_rn (.clk, .en, .num_i(an_r), .den_i({1'b0, dnv_r}), .quo_o(quo.rn));
  lsfr_div u_div_rp (.clk, .en, .num_i(ap_r), .den_i({1'b0, dpv_r}), .quo_o(quo.rp));
  lsfr_div u_div_wn (.clk, .en, .num_i({1'b0, dnv_r}), .den_i(sum_r), .quo_o(quo.wn));

  // side data delay line matching the divider depth
  side_t side_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side0_r;
      for (int i = 1; i < DIV_LAT; i++)
        side_r[i] <= side_r[i-1];
    end
  end

  // ---- limiting and face values
  logic signed [31:0] face_m, face_p;
  logic               vm, vp;

  lsfr_face u_face (
    .clk, .en,
    .quo_i    (quo),
    .side_i   (side_r[DIV_LAT-1]),
    .face_m_o (face_m),
    .face_p_o (face_p),
    .vm_o     (vm),
    .vp_o     (vp)
  );

  // ---- valid chain
  logic [LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {face_p, face_m};
  assign out_tuser  = {vp, vm};

endmodule

[rtl/core/lsfr_div.sv]
// ----------------------------------------------------------------------------
// lsfr_div
// Pipelined restoring divider: floor(num * 2^16 / den), saturated to 32 bits.
// ----------------------------------------------------------------------------
module lsfr_div import lsfr_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [MW-1:0] num_i,
  input  logic [MW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  localparam int RW = MW + FRAC;      // dividend width
  localparam int SW = MW + QW;        // shifted divisor width

  logic [RW-1:0] rem_r [0:DIV_STGS];
  logic [MW-1:0] den_r [0:DIV_STGS];
  logic [QW-1:0] q_r   [0:DIV_STGS];
  logic          sat_r [0:DIV_STGS];

  // quotient overflows (or den is zero) when num*2^16 >= den*2^32
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {num_i, {FRAC{1'b0}}};
      den_r[0] <= den_i;
      q_r[0]   <= '0;
      sat_r[0] <= (den_i == '0) ||
                  ({{(SW-RW){1'b0}}, num_i, {FRAC{1'b0}}} >= {den_i, {QW{1'b0}}});
    end
  end

  for (genvar k = 1; k <= DIV_STGS; k++) begin : g_stg
    localparam int B = DIV_STGS - k;
    logic [SW-1:0] sub;
    logic          ge;

    assign sub = {{QW{1'b0}}, den_r[k-1]} << B;
    assign ge  = {{(SW-RW){1'b0}}, rem_r[k-1]} >= sub;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? (rem_r[k-1] - sub[RW-1:0]) : rem_r[k-1];
        den_r[k] <= den_r[k-1];
        q_r[k]   <= q_r[k-1] | (ge ? (QW'(1) << B) : '0);
        sat_r[k] <= sat_r[k-1];
      end
    end
  end

  assign quo_o = sat_r[DIV_STGS] ? SMAX : q_r[DIV_STGS];

endmodule

[rtl/core/lsfr_face.sv]
// ----------------------------------------------------------------------------
// lsfr_face
// Slope limiting, lever arms and face values; four register stages.
// ----------------------------------------------------------------------------
module lsfr_face import lsfr_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  quo_t               quo_i,
  input  side_t              side_i,
  output logic signed [31:0] face_m_o,
  output logic signed [31:0] face_p_o,
  output logic               vm_o,
  output logic               vp_o
);

  // ---- stage 1: one-sided minimum, weighted products
  logic [QW-1:0]   smin_r;
  logic [48:0]     p1_r, p2_r;
  side_t           s1_r;
  logic [FRAC:0]   wn17, wp17;

  assign wn17 = quo_i.wn[FRAC:0];
  assign wp17 = (17'(1) << FRAC) - wn17;

  always_ff @(posedge clk) begin
    if (en) begin
      smin_r <= (quo_i.sn < quo_i.sp) ? quo_i.sn : quo_i.sp;
      p1_r   <= quo_i.rp * wn17;
      p2_r   <= quo_i.rn * wp17;
      s1_r   <= side_i;
    end
  end

  // ---- stage 2: three-point estimate, final slope, lever arms
  logic [49:0]        psum;
  logic [QW-1:0]      sc, slope_nxt;
  logic signed [33:0] lev_m, lev_p;
  logic [QW-1:0]      slope_r, lmag_m_r, lmag_p_r;
  logic               lneg_m_r, lneg_p_r, neg2_r, vm2_r, vp2_r;
  logic signed [31:0] phi2_r;

  assign psum = {1'b0, p1_r} + {1'b0, p2_r};
  assign sc   = s1_r.sum_zero ? SMAX : psum[QW+FRAC-1:FRAC];
  assign slope_nxt = !s1_r.active ? '0 : ((smin_r < sc) ? smin_r : sc);
  // twice the lever arm: 2*near - swept
  assign lev_m = $signed({2'b0, s1_r.near_m, 1'b0}) - $signed({3'b0, s1_r.swept_m});
  assign lev_p = $signed({2'b0, s1_r.near_p, 1'b0}) - $signed({3'b0, s1_r.swept_p});

  always_ff @(posedge clk) begin
    if (en) begin
      slope_r  <= slope_nxt;
      lneg_m_r <= lev_m[33];
      lneg_p_r <= lev_p[33];
      lmag_m_r <= lev_m[33] ? 32'(-lev_m) : lev_m[31:0];
      lmag_p_r <= lev_p[33] ? 32'(-lev_p) : lev_p[31:0];
      neg2_r   <= s1_r.neg;
      phi2_r   <= s1_r.phi;
      vm2_r    <= (s1_r.swept_m != '0);
      vp2_r    <= (s1_r.swept_p != '0);
    end
  end

  // ---- stage 3: correction products
  logic [63:0]        prod_m_r, prod_p_r;
  logic               cneg_m_r, cneg_p_r, vm3_r, vp3_r;
  logic signed [31:0] phi3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_m_r <= slope_r * lmag_m_r;
      prod_p_r <= slope_r * lmag_p_r;
      cneg_m_r <= neg2_r ^ lneg_m_r;
      cneg_p_r <= neg2_r ^ lneg_p_r;
      phi3_r   <= phi2_r;
      vm3_r    <= vm2_r;
      vp3_r    <= vp2_r;
    end
  end

  // ---- stage 4: apply correction and saturate
  function automatic logic signed [31:0] face_sat(
    input logic signed [31:0] phi,
    input logic [63:0]        prod,
    input logic               cneg
  );
    logic [46:0]        corr;
    logic signed [48:0] f;
    begin
      corr = prod[63:17];
      if (cneg)
        f = $signed({{17{phi[31]}}, phi}) + $signed({2'b0, corr});
      else
        f = $signed({{17{phi[31]}}, phi}) - $signed({2'b0, corr});
      if (f > 49'sd2147483647)
        face_sat = 32'sh7FFFFFFF;
      else if (f < -49'sd2147483648)
        face_sat = 32'sh80000000;
      else
        face_sat = f[31:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      face_m_o <= vm3_r ? face_sat(phi3_r, prod_m_r, cneg_m_r) : '0;
      face_p_o <= vp3_r ? face_sat(phi3_r, prod_p_r, cneg_p_r) : '0;
      vm_o     <= vm3_r;
      vp_o     <= vp3_r;
    end
  end

endmodule

[rtl/core/lsfr_chk.sv]
// ----------------------------------------------------------------------------
// lsfr_chk
// Port-level checks for the face reconstruction pipe, bound to the top level.
// ----------------------------------------------------------------------------
module lsfr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // pipe takes a request whenever its output slot frees up
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_face_m_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[31:0] == 32'd0)
    else $error("minus face nonzero without valid flag");

  a_face_p_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata[63:32] == 32'd0)
    else $error("plus face nonzero without valid flag");

  // first edge out of reset: pipe is empty
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind limited_slope_face_reconstruction lsfr_chk u_lsfr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
